>>> src/hqa_pkg.sv
// ----------------------------------------------------------------------------
// Helicity quartet asymmetry package
// Widths, the quartet helicity pattern and the record passed from the
// sequence checker to the divider.
// ----------------------------------------------------------------------------
package hqa_pkg;

	localparam int COUNT_BITS = 32;
	localparam int FRAC_BITS  = 15;

	// Plain sum of four counts, and signed sum with one sign bit on top.
	localparam int PLAIN_W = COUNT_BITS + 2;
	localparam int SUM_W   = COUNT_BITS + 3;

	// Asymmetry in signed Q1.FRAC_BITS.
	localparam int ASYM_W = FRAC_BITS + 1;

	// Quotient bits needed: one integer bit, FRAC_BITS fraction bits, one round bit.
	localparam int QBITS = FRAC_BITS + 2;
	// Two quotient bits are produced per cycle.
	localparam int ITERS = (QBITS + 1) / 2;
	localparam int NBITS = 2 * ITERS;
	localparam int IT_W  = $clog2(ITERS + 1);

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Phase with no quartet open.
	localparam logic [1:0] PH_NONE = 2'd0;
	localparam logic [1:0] PH_LAST = 2'd3;

	// Helicity codes.
	localparam logic [1:0] HEL_POS = 2'b01;
	localparam logic [1:0] HEL_NEG = 2'b11;

	// Bit n set where the pattern +,-,-,+ is negative at phase n.
	localparam logic [3:0] QUARTET_NEG = 4'b0110;

	typedef struct packed {
		logic signed [SUM_W-1:0] ssum;
		logic [PLAIN_W-1:0]      psum;
	} quartet_t;

endpackage

>>> src/helicity_quartet_asymmetry_top.sv
// Each result lands in the output register after the phase 3 reading that closes
//   its quartet has passed through the queue and the divider.
// Throughput: one reading per cycle at the input while the queue is not full; the
//   divider takes the next quartet only as it finishes the last (9 radix-4 steps plus the result load).
// Reset: arst_n clears the quartet state, the queue, the counters and the
//   statistics at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// Helicity quartet asymmetry
// Checks helicity quartets in scaler readings and reports the asymmetry of
// each good quartet together with the running count, minimum and maximum.
// ----------------------------------------------------------------------------
module helicity_quartet_asymmetry_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [1:0]  helicity,
	input  logic [1:0]         phase,
	input  logic [31:0]        count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] asymmetry,
	output logic [31:0]        quartet_number,
	output logic signed [15:0] min_asymmetry,
	output logic signed [15:0] max_asymmetry
);

	// The front end checks the phase order and helicity pattern of every
	// transfer and keeps the running sums. It never waits on the divider
	// unless the queue is full, so readings stream in at one per cycle.
	hqa_pkg::quartet_t push_data;
	hqa_pkg::quartet_t pop_data;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;

	hqa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.helicity (helicity),
		.phase    (phase),
		.count    (count),
		.q_full   (q_full),
		.q_push   (push),
		.q_data   (push_data)
	);

	// Completed quartets wait here, so the checker keeps taking readings
	// while the divider works or while a result sits unclaimed downstream.
	hqa_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (pop_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	// The back end divides the signed sum by the plain sum, rounds and
	// saturates to Q1.15, updates the statistics and holds the result in
	// its output register until the transfer completes.
	hqa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_data         (pop_data),
		.q_empty        (q_empty),
		.q_pop          (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.asymmetry      (asymmetry),
		.quartet_number (quartet_number),
		.min_asymmetry  (min_asymmetry),
		.max_asymmetry  (max_asymmetry)
	);

endmodule

>>> src/hqa_front.sv
// ----------------------------------------------------------------------------
// Quartet sequence checker
// Checks phase order and helicity pattern, accumulates the signed and plain
// sums and hands each completed quartet with a nonzero plain sum to the queue.
// ----------------------------------------------------------------------------
module hqa_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [1:0]    helicity,
	input  logic [1:0]           phase,
	input  logic [31:0]          count,
	input  logic                 q_full,
	output logic                 q_push,
	output hqa_pkg::quartet_t    q_data
);

	logic [1:0]                         exp_phase_q;
	logic                               polarity_q;
	logic signed [hqa_pkg::SUM_W-1:0]   ssum_q;
	logic [hqa_pkg::PLAIN_W-1:0]        psum_q;

	logic                               accept;
	logic                               hel_ok;
	logic                               hel_neg;
	logic                               match;
	logic signed [hqa_pkg::SUM_W-1:0]   cnt_ext;
	logic signed [hqa_pkg::SUM_W-1:0]   sterm;
	logic signed [hqa_pkg::SUM_W-1:0]   ssum_n;
	logic [hqa_pkg::PLAIN_W-1:0]        psum_n;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign hel_ok  = (helicity == hqa_pkg::HEL_POS) || (helicity == hqa_pkg::HEL_NEG);
	assign hel_neg = (helicity == hqa_pkg::HEL_NEG);

	assign cnt_ext = {{(hqa_pkg::SUM_W - hqa_pkg::COUNT_BITS){1'b0}},
		count[hqa_pkg::COUNT_BITS-1:0]};
	assign sterm   = hel_neg ? -cnt_ext : cnt_ext;
	assign ssum_n  = ssum_q + sterm;
	assign psum_n  = psum_q + cnt_ext[hqa_pkg::PLAIN_W-1:0];

	// A continuing reading must be the expected phase with the pattern's sign.
	assign match = (exp_phase_q != hqa_pkg::PH_NONE) && (phase == exp_phase_q) &&
		(hel_neg == (polarity_q ^ hqa_pkg::QUARTET_NEG[phase]));

	assign q_push      = accept && hel_ok && (phase != hqa_pkg::PH_NONE) && match &&
		(phase == hqa_pkg::PH_LAST) && (psum_n != '0);
	assign q_data.ssum = ssum_n;
	assign q_data.psum = psum_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_phase_q <= hqa_pkg::PH_NONE;
			polarity_q  <= 1'b0;
			ssum_q      <= '0;
			psum_q      <= '0;
		end else if (accept && hel_ok) begin
			if (phase == hqa_pkg::PH_NONE) begin
				polarity_q  <= hel_neg;
				ssum_q      <= sterm;
				psum_q      <= cnt_ext[hqa_pkg::PLAIN_W-1:0];
				exp_phase_q <= 2'd1;
			end else if (!match) begin
				exp_phase_q <= hqa_pkg::PH_NONE;
			end else begin
				ssum_q <= ssum_n;
				psum_q <= psum_n;
				if (phase == hqa_pkg::PH_LAST) begin
					exp_phase_q <= hqa_pkg::PH_NONE;
				end else begin
					exp_phase_q <= phase + 2'd1;
				end
			end
		end
	end

endmodule

>>> src/hqa_fifo.sv
// ----------------------------------------------------------------------------
// Quartet queue
// Short first-in first-out buffer between the checker and the divider.
// ----------------------------------------------------------------------------
module hqa_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hqa_pkg::quartet_t wr_data,
	input  logic              pop,
	output hqa_pkg::quartet_t rd_data,
	output logic              full,
	output logic              empty
);

	hqa_pkg::quartet_t                mem [hqa_pkg::FIFO_DEPTH];
	logic [hqa_pkg::FIFO_AW-1:0]      wr_ptr_q;
	logic [hqa_pkg::FIFO_AW-1:0]      rd_ptr_q;
	logic [hqa_pkg::FIFO_AW:0]        fill_q;

	assign full    = (fill_q == (hqa_pkg::FIFO_AW + 1)'(hqa_pkg::FIFO_DEPTH));
	assign empty   = (fill_q == '0);
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == hqa_pkg::FIFO_AW'(hqa_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == hqa_pkg::FIFO_AW'(hqa_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> src/hqa_back.sv
// ----------------------------------------------------------------------------
// Asymmetry divider and statistics
// Restoring division, two quotient bits a cycle, then rounding, saturation,
// running minimum, maximum and quartet count, held in the output register.
// ----------------------------------------------------------------------------
module hqa_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  hqa_pkg::quartet_t                  q_data,
	input  logic                               q_empty,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [hqa_pkg::ASYM_W-1:0]  asymmetry,
	output logic [31:0]                        quartet_number,
	output logic signed [hqa_pkg::ASYM_W-1:0]  min_asymmetry,
	output logic signed [hqa_pkg::ASYM_W-1:0]  max_asymmetry
);

	localparam int R_W = hqa_pkg::PLAIN_W + 1;

	logic                                busy_q;
	logic [hqa_pkg::IT_W-1:0]            it_q;
	logic                                neg_q;
	logic [R_W-1:0]                      rem_q;
	logic [R_W-1:0]                      den_q;
	logic [hqa_pkg::NBITS-1:0]           quo_q;
	logic                                out_valid_q;
	logic signed [hqa_pkg::ASYM_W-1:0]   asym_q;
	logic signed [hqa_pkg::ASYM_W-1:0]   min_q;
	logic signed [hqa_pkg::ASYM_W-1:0]   max_q;
	logic [31:0]                         num_q;

	logic                                fin;
	logic                                b1;
	logic                                b2;
	logic [R_W-1:0]                      r1;
	logic [R_W-1:0]                      r2;
	logic [R_W-1:0]                      r3;
	logic signed [hqa_pkg::SUM_W-1:0]    mag_s;
	logic [hqa_pkg::QBITS-1:0]           q_full;
	logic [hqa_pkg::ASYM_W:0]            q_rnd;
	logic signed [hqa_pkg::ASYM_W-1:0]   a;

	assign fin   = busy_q && (it_q == hqa_pkg::IT_W'(hqa_pkg::ITERS)) &&
		(!out_valid_q || out_ready);
	assign q_pop = !q_empty && (!busy_q || fin);

	// Two restoring steps; the remainder stays below twice the divisor.
	always_comb begin
		b1 = (rem_q >= den_q);
		r1 = b1 ? rem_q - den_q : rem_q;
		r2 = {r1[R_W-2:0], 1'b0};
		b2 = (r2 >= den_q);
		r3 = b2 ? r2 - den_q : r2;
		r3 = {r3[R_W-2:0], 1'b0};
	end

	assign mag_s = q_data.ssum[hqa_pkg::SUM_W-1] ? -q_data.ssum : q_data.ssum;

	// Drop surplus low bits, then round half away from zero on magnitude.
	always_comb begin
		q_full = quo_q[hqa_pkg::NBITS-1 -: hqa_pkg::QBITS];
		q_rnd  = (hqa_pkg::ASYM_W + 1)'(q_full[hqa_pkg::QBITS-1:1]) +
			(hqa_pkg::ASYM_W + 1)'(q_full[0]);
		if (neg_q) begin
			a = -q_rnd[hqa_pkg::ASYM_W-1:0];
		end else if (q_rnd >= (hqa_pkg::ASYM_W + 1)'(1 << hqa_pkg::FRAC_BITS)) begin
			a = hqa_pkg::ASYM_W'((1 << hqa_pkg::FRAC_BITS) - 1);
		end else begin
			a = q_rnd[hqa_pkg::ASYM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			neg_q <= q_data.ssum[hqa_pkg::SUM_W-1];
			rem_q <= {1'b0, mag_s[hqa_pkg::PLAIN_W-1:0]};
			den_q <= {1'b0, q_data.psum};
			quo_q <= '0;
		end else if (busy_q && (it_q != hqa_pkg::IT_W'(hqa_pkg::ITERS))) begin
			rem_q <= r3;
			quo_q <= {quo_q[hqa_pkg::NBITS-3:0], b1, b2};
		end
		if (fin) begin
			asym_q <= a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			it_q        <= '0;
			out_valid_q <= 1'b0;
			min_q       <= '0;
			max_q       <= '0;
			num_q       <= '0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (busy_q && (it_q != hqa_pkg::IT_W'(hqa_pkg::ITERS))) begin
				it_q <= it_q + 1'b1;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
				num_q       <= num_q + 32'd1;
				if (a < min_q) begin
					min_q <= a;
				end
				if (a > max_q) begin
					max_q <= a;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign asymmetry      = asym_q;
	assign quartet_number = num_q;
	assign min_asymmetry  = min_q;
	assign max_asymmetry  = max_q;

endmodule

>>> tb/sv/hqa_checker.sv
// ----------------------------------------------------------------------------
// Helicity quartet asymmetry checker
// Watches both channels of the block, tracks the quartet sequence on every
// input transfer and compares each output transfer with the oldest outcome.
// ----------------------------------------------------------------------------
module hqa_checker
	import hqa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [1:0]  helicity,
	input  logic [1:0]         phase,
	input  logic [31:0]        count,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] asymmetry,
	input  logic [31:0]        quartet_number,
	input  logic signed [15:0] min_asymmetry,
	input  logic signed [15:0] max_asymmetry,
	output int                 mismatches,
	output int                 outstanding
);

	localparam logic [1:0] PH_START = 2'd0;

	typedef struct {
		logic signed [ASYM_W-1:0] asym;
		logic [31:0]              qnum;
		logic signed [ASYM_W-1:0] amin;
		logic signed [ASYM_W-1:0] amax;
	} quartet_outcome_t;

	quartet_outcome_t outcome_q[$];

	// Tracked sequence state.
	logic [1:0]               next_phase;
	bit                       pol_negative;
	longint                   signed_total;
	longint                   plain_total;
	logic [31:0]              quartets_seen;
	logic signed [ASYM_W-1:0] asym_low;
	logic signed [ASYM_W-1:0] asym_high;

	// Restoring division with one round bit, then saturation to Q1.FRAC_BITS.
	function automatic logic signed [ASYM_W-1:0] q_ratio(input longint num,
		input longint den);
		bit              neg;
		longint unsigned rem;
		longint unsigned dvs;
		longint unsigned quo;
		longint          val;
		longint          lim;
		int              i;
		neg = num < 0;
		rem = neg ? -num : num;
		dvs = den;
		quo = 0;
		lim = longint'(1) << FRAC_BITS;
		if (rem >= dvs) begin
			quo = 1;
			rem = rem - dvs;
		end
		for (i = 0; i < FRAC_BITS; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= dvs) begin
				quo = quo | 1;
				rem = rem - dvs;
			end
		end
		rem = rem << 1;
		if (rem >= dvs)
			quo = quo + 1;
		val = neg ? -longint'(quo) : longint'(quo);
		if (val > lim - 1)
			val = lim - 1;
		if (val < -lim)
			val = -lim;
		return val[ASYM_W-1:0];
	endfunction

	// Advances the sequence state by one reading; returns 1 when a quartet
	// completes with a nonzero plain sum.
	function automatic bit track_reading(input logic [1:0] hel, input logic [1:0] ph,
		input logic [31:0] cnt, output quartet_outcome_t res);
		bit     is_neg;
		bit     want_neg;
		longint c;
		logic signed [ASYM_W-1:0] a;
		res = '{default: '0};
		if (hel != HEL_POS && hel != HEL_NEG)
			return 0;
		is_neg = (hel == HEL_NEG);
		c = longint'({32'd0, cnt});
		if (ph == PH_START) begin
			pol_negative = is_neg;
			signed_total = is_neg ? -c : c;
			plain_total  = c;
			next_phase   = ph + 2'd1;
			return 0;
		end
		want_neg = QUARTET_NEG[ph] ^ pol_negative;
		if (next_phase == PH_NONE || ph != next_phase || is_neg != want_neg) begin
			next_phase = PH_NONE;
			return 0;
		end
		signed_total += is_neg ? -c : c;
		plain_total  += c;
		if (ph != PH_LAST) begin
			next_phase = ph + 2'd1;
			return 0;
		end
		next_phase = PH_NONE;
		if (plain_total == 0)
			return 0;
		a = q_ratio(signed_total, plain_total);
		quartets_seen = quartets_seen + 32'd1;
		if (a > asym_high)
			asym_high = a;
		if (a < asym_low)
			asym_low = a;
		res.asym = a;
		res.qnum = quartets_seen;
		res.amin = asym_low;
		res.amax = asym_high;
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quartet_outcome_t want;
		quartet_outcome_t got;
		string            exp_txt;
		string            got_txt;
		if (!arst_n) begin
			next_phase    = PH_NONE;
			pol_negative  = 0;
			signed_total  = 0;
			plain_total   = 0;
			quartets_seen = '0;
			asym_low      = '0;
			asym_high     = '0;
			outcome_q.delete();
			mismatches    = 0;
			outstanding   = 0;
		end else begin
			if (out_valid && out_ready) begin
				got.asym = asymmetry;
				got.qnum = quartet_number;
				got.amin = min_asymmetry;
				got.amax = max_asymmetry;
				if (outcome_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: asym %0d count %0d min %0d max %0d",
							got.asym, got.qnum, got.amin, got.amax);
				end else begin
					want = outcome_q.pop_front();
					if (got.asym !== want.asym || got.qnum !== want.qnum ||
						got.amin !== want.amin || got.amax !== want.amax) begin
						mismatches++;
						if (mismatches <= 10) begin
							exp_txt = $sformatf("asym %0d count %0d min %0d max %0d",
								want.asym, want.qnum, want.amin, want.amax);
							got_txt = $sformatf("asym %0d count %0d min %0d max %0d",
								got.asym, got.qnum, got.amin, got.amax);
							$display("mismatch: expected %s, got %s", exp_txt, got_txt);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				if (track_reading(helicity, phase, count, want))
					outcome_q.push_back(want);
			end
			outstanding = outcome_q.size();
		end
	end

endmodule

>>> tb/sv/tb_helicity_quartet_asymmetry_top.sv
// ----------------------------------------------------------------------------
// Helicity quartet asymmetry testbench
// Drives scaler readings into the block, mostly as well-formed quartets with
// random counts and some noise, under several sender and receiver idling
// phases; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_helicity_quartet_asymmetry_top;
	import hqa_pkg::*;

	// Helicity codes the block skips: undetermined, and the unused pattern.
	localparam logic [1:0] HEL_NONE = 2'b00;
	localparam logic [1:0] HEL_ODD  = 2'b10;

	// All inputs start at known values so nothing is X at time zero.
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [1:0]  helicity = '0;
	logic [1:0]         phase = '0;
	logic [31:0]        count = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] asymmetry;
	logic [31:0]        quartet_number;
	logic signed [15:0] min_asymmetry;
	logic signed [15:0] max_asymmetry;

	int mismatches;
	int outstanding;

	// Percent of cycles in which the sender holds back and the receiver stalls.
	int idle_pct = 0;
	int stall_pct = 0;
	// Readings with a real helicity that have been transferred so far.
	int readings_sent = 0;
	// Registered at the rising edge: the reading on the bus was transferred.
	logic in_took = 1'b0;

	helicity_quartet_asymmetry_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.helicity       (helicity),
		.phase          (phase),
		.count          (count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.asymmetry      (asymmetry),
		.quartet_number (quartet_number),
		.min_asymmetry  (min_asymmetry),
		.max_asymmetry  (max_asymmetry)
	);

	hqa_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.helicity       (helicity),
		.phase          (phase),
		.count          (count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.asymmetry      (asymmetry),
		.quartet_number (quartet_number),
		.min_asymmetry  (min_asymmetry),
		.max_asymmetry  (max_asymmetry),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The handshake is sampled at the rising edge; the driver looks at this
	// flag at the following falling edge, when it is settled.
	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
	end

	// The receiver decides afresh every cycle whether it takes a result.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// A generous bound: it allows far more time than the slowest phases need
	// for every reading.
	initial begin
		#3000000;
		$display("tb_helicity_quartet_asymmetry_top NOT OK");
		$finish;
	end

	// Counts shaped so that zero, tiny, full-scale and mid-range values all
	// show up; mixing zeros with large counts drives the ratio to its limits.
	function automatic logic [31:0] pick_count();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return $urandom_range(1, 15);
			2: return $urandom;
			3: return 32'hFFFF_FFFF;
			4: return $urandom_range(0, 1000);
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	// Puts one reading on the bus after a random hold-off and returns at the
	// falling edge after its transfer, so the next one can follow at once.
	task automatic send_reading(input logic [1:0] hel, input logic [1:0] ph,
		input logic [31:0] cnt);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		helicity <= hel;
		phase    <= ph;
		count    <= cnt;
		@(negedge clk);
		while (!in_took)
			@(negedge clk);
		if (hel == HEL_POS || hel == HEL_NEG)
			readings_sent++;
	endtask

	// Helicity that the pattern calls for at a phase, for a given polarity.
	function automatic logic [1:0] pattern_hel(input bit pol_neg, input int ph);
		return (QUARTET_NEG[ph] ^ pol_neg) ? HEL_NEG : HEL_POS;
	endfunction

	task automatic send_quartet(input bit pol_neg, input logic [31:0] c0,
		input logic [31:0] c1, input logic [31:0] c2, input logic [31:0] c3);
		send_reading(pattern_hel(pol_neg, 0), 2'd0, c0);
		send_reading(pattern_hel(pol_neg, 1), 2'd1, c1);
		send_reading(pattern_hel(pol_neg, 2), 2'd2, c2);
		send_reading(pattern_hel(pol_neg, 3), 2'd3, c3);
	endtask

	// A quartet with random content. Now and then a skipped reading is slipped
	// in, or one reading is broken: wrong helicity, wrong phase, or missing.
	task automatic random_quartet();
		bit         pol_neg;
		bit         all_zero;
		int         ph;
		int         roll;
		logic [1:0] hel;
		logic [1:0] p;
		pol_neg  = 1'($urandom_range(1));
		all_zero = ($urandom_range(0, 39) == 0);
		for (ph = 0; ph < 4; ph++) begin
			if ($urandom_range(0, 19) == 0)
				send_reading($urandom_range(1) ? HEL_NONE : HEL_ODD,
					2'($urandom_range(3)), $urandom);
			hel  = pattern_hel(pol_neg, ph);
			p    = 2'(ph);
			roll = $urandom_range(0, 99);
			if (roll < 3)
				hel = (hel == HEL_POS) ? HEL_NEG : HEL_POS;
			else if (roll < 6)
				p = 2'($urandom_range(3));
			if (roll >= 6 && roll < 8)
				continue;
			send_reading(hel, p, all_zero ? 32'd0 : pick_count());
		end
	endtask

	// Pause the sender until every outstanding result has been taken, then
	// give the divider a little longer in case a quartet is still in flight.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	initial begin
		int idle_set[4];
		int stall_set[4];
		int k;
		int quota;
		idle_set  = '{0, 85, 0, 20};
		stall_set = '{0, 0, 85, 20};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with no idling on either side.
		// Only the positive windows count: saturates at just under plus one.
		send_quartet(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
		// Negative polarity with only its first window counting: exactly minus one.
		send_quartet(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
		// Undetermined helicity and the unused helicity code are skipped.
		send_reading(HEL_POS, 2'd0, 32'd1);
		send_reading(HEL_NONE, 2'd2, 32'd99);
		send_reading(HEL_NEG, 2'd1, 32'd2);
		send_reading(HEL_ODD, 2'd3, 32'hFFFF_FFFF);
		send_reading(HEL_NEG, 2'd2, 32'd3);
		send_reading(HEL_POS, 2'd3, 32'd7);
		// A phase 0 inside an open quartet restarts it with the new polarity.
		send_reading(HEL_POS, 2'd0, 32'd100);
		send_quartet(1'b1, 32'd5, 32'd9, 32'd1, 32'd2);
		// Out-of-order phase abandons the quartet; the next phase finds none open.
		send_reading(HEL_POS, 2'd0, 32'd4);
		send_reading(HEL_NEG, 2'd2, 32'd4);
		send_reading(HEL_NEG, 2'd1, 32'd4);
		// Wrong helicity abandons the quartet.
		send_reading(HEL_POS, 2'd0, 32'd8);
		send_reading(HEL_POS, 2'd1, 32'd8);
		// A complete quartet with zero plain sum gives no result.
		send_quartet(1'b0, 32'd0, 32'd0, 32'd0, 32'd0);
		drain();

		// Random part: one phase per idling setting, each ending with a drain.
		for (k = 0; k < 4; k++) begin
			idle_pct  = idle_set[k];
			stall_pct = stall_set[k];
			quota     = readings_sent + 310;
			while (readings_sent < quota) begin
				if ($urandom_range(0, 9) < 8)
					random_quartet();
				else
					send_reading(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom);
			end
			drain();
		end

		// Let the receiver take everything for the final wait.
		stall_pct = 0;
		repeat (20) @(negedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("tb_helicity_quartet_asymmetry_top OK");
		else
			$display("tb_helicity_quartet_asymmetry_top NOT OK");
		$finish;
	end

endmodule
